FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk, off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSRD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MSRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/msrd_pkg.sv
// ---------------------------------------------------------------------------
// msrd_pkg
// types and constants of the monochrome sprite run-length decoder
// ---------------------------------------------------------------------------
package msrd_pkg;

	// code byte values
	localparam logic [7:0] CODE_NEWLINE = 8'h00;
	localparam logic [7:0] CODE_END     = 8'h80;
	localparam logic [6:0] RUN_MASK     = 7'h7F;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;

	// reset values
	localparam logic [15:0] ROW_WIDTH_RST = 16'd64;
	localparam logic [15:0] ROW_COUNT_RST = 16'd64;
	localparam logic [31:0] TOTAL_RST     = 32'd4096;

	// one decoded run
	typedef struct packed {
		logic        pixel_color;
		logic [31:0] run_length;
		logic        overflow;
		logic        last_run;
	} run_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [15:0] row_width;
		logic [31:0] total;
		logic        refresh;
	} cfg_t;

endpackage

FILE: rtl/msrd_if.sv
// ---------------------------------------------------------------------------
// msrd channel interfaces
// code byte input, run output and configuration write channels
// ---------------------------------------------------------------------------

// code byte channel
interface msrd_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

// run channel
interface msrd_run_if;
	logic        valid;
	logic        ready;
	logic        pixel_color;
	logic [31:0] run_length;
	logic        overflow;
	logic        last_run;

	modport source (output valid, output pixel_color, output run_length,
		output overflow, output last_run, input ready);
	modport sink (input valid, input pixel_color, input run_length,
		input overflow, input last_run, output ready);
endinterface

// configuration write channel
interface msrd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [msrd_pkg::CFG_IDX_W-1:0] index;
	logic [15:0]                   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mono_sprite_rle_decoder.sv
// ---------------------------------------------------------------------------
// mono_sprite_rle_decoder
// decodes monochrome sprite code bytes into pixel runs, one run per byte
// ---------------------------------------------------------------------------
// channel   | dir | payload                                         | request
// code_in   | in  | code_byte[7:0]                                  | one code byte
// run_out   | out | pixel_color, run_length[31:0], overflow, last_run | one run
// cfg       | in  | index[1:0], data[15:0]                          | register write
//
// one byte per cycle while run_out is ready and no register write settles;
// code_in reaches run_out via the input register, then the run register, with
// the combinational run unit between; a register write holds code_in.ready low
// while the remaining-pixel count settles; arst_n sets the sizes to 64 by 64,
// the remaining count to 4096 and clears the column and emitted-pixel counts;
// a stalled run_out holds the run register and backs up into code_in
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mono_sprite_rle_decoder (
	input  logic        clk,
	input  logic        arst_n,
	msrd_cfg_if.sink    cfg,
	msrd_code_if.sink   code_in,
	msrd_run_if.source  run_out
);

	msrd_pkg::cfg_t cfg_c;
	msrd_pkg::run_t run_c;
	msrd_pkg::run_t run_q;

	logic [7:0]  code_s1;
	logic        valid_s1;
	logic        out_valid_q;
	logic        adv;
	logic [15:0] column_q;
	logic [31:0] rest_q;
	logic [31:0] emitted_q;
	logic [15:0] column_nxt;
	logic [31:0] rest_nxt;
	logic [31:0] emitted_nxt;

	msrd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_c)
	);

	msrd_run_unit u_run (
		.code_byte   (code_s1),
		.cfg         (cfg_c),
		.column      (column_q),
		.rest        (rest_q),
		.emitted     (emitted_q),
		.run         (run_c),
		.column_nxt  (column_nxt),
		.rest_nxt    (rest_nxt),
		.emitted_nxt (emitted_nxt)
	);

	// handshake control
	assign adv           = valid_s1 && !cfg_c.refresh && (!out_valid_q || run_out.ready);
	assign code_in.ready = !cfg_c.refresh && (!valid_s1 || adv);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_in.ready) begin
			valid_s1 <= code_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_in.valid && code_in.ready) begin
			code_s1 <= code_in.code_byte;
		end
	end

	// decoder state, resynced after a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= 16'd0;
			rest_q    <= msrd_pkg::TOTAL_RST;
			emitted_q <= 32'd0;
		end else if (cfg_c.refresh) begin
			rest_q <= (emitted_q < cfg_c.total) ? (cfg_c.total - emitted_q) : 32'd0;
		end else if (adv) begin
			column_q  <= column_nxt;
			rest_q    <= rest_nxt;
			emitted_q <= emitted_nxt;
		end
	end

	// run register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (run_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			run_q <= run_c;
		end
	end

	assign run_out.valid       = out_valid_q;
	assign run_out.pixel_color = run_q.pixel_color;
	assign run_out.run_length  = run_q.run_length;
	assign run_out.overflow    = run_q.overflow;
	assign run_out.last_run    = run_q.last_run;

	// checks
	`MSRD_ASSERT_IMPL(a_rest_in_total, !cfg_c.refresh, rest_q <= cfg_c.total)
	`MSRD_ASSERT_NEXT(a_end_clears, adv && run_c.last_run, column_q == 16'd0 && emitted_q == 32'd0)
	`MSRD_ASSERT_NEXT(a_clip_empties, adv && run_c.overflow, rest_q == 32'd0)
	`MSRD_ASSERT_IMPL(a_last_not_clipped, out_valid_q, !(run_q.overflow && run_q.last_run))

endmodule

FILE: rtl/msrd_cfg_regs.sv
// ---------------------------------------------------------------------------
// msrd_cfg_regs
// sprite size registers with the image pixel total kept alongside
// ---------------------------------------------------------------------------
module msrd_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	msrd_cfg_if.sink        cfg,
	output msrd_pkg::cfg_t  cfg_out
);

	logic [15:0] row_width_q;
	logic [15:0] row_count_q;
	logic [31:0] total_q;
	logic        refresh_q;
	logic        wr;
	logic [31:0] prod_w;
	logic [31:0] prod_c;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	// new total from the written value and the other register
	assign prod_w = {16'd0, cfg.data} * {16'd0, row_count_q};
	assign prod_c = {16'd0, row_width_q} * {16'd0, cfg.data};

	// register writes, total follows in the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= msrd_pkg::ROW_WIDTH_RST;
			row_count_q <= msrd_pkg::ROW_COUNT_RST;
			total_q     <= msrd_pkg::TOTAL_RST;
			refresh_q   <= 1'b0;
		end else begin
			refresh_q <= wr;
			if (wr) begin
				unique case (cfg.index)
					msrd_pkg::CFG_ROW_WIDTH: begin
						row_width_q <= cfg.data;
						total_q     <= prod_w;
					end
					msrd_pkg::CFG_ROW_COUNT: begin
						row_count_q <= cfg.data;
						total_q     <= prod_c;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg_out.row_width = row_width_q;
	assign cfg_out.total     = total_q;
	assign cfg_out.refresh   = refresh_q;

endmodule

FILE: rtl/msrd_run_unit.sv
// ---------------------------------------------------------------------------
// msrd_run_unit
// turns one code byte into a run and the next decoder state
// ---------------------------------------------------------------------------
module msrd_run_unit (
	input  logic [7:0]      code_byte,
	input  msrd_pkg::cfg_t  cfg,
	input  logic [15:0]     column,
	input  logic [31:0]     rest,
	input  logic [31:0]     emitted,
	output msrd_pkg::run_t  run,
	output logic [15:0]     column_nxt,
	output logic [31:0]     rest_nxt,
	output logic [31:0]     emitted_nxt
);

	logic        is_end;
	logic        is_newline;
	logic [15:0] fill_len;
	logic [31:0] len_raw;
	logic        clip;
	logic [31:0] len;
	logic [15:0] column_sum;

	assign is_end     = (code_byte == msrd_pkg::CODE_END);
	assign is_newline = (code_byte == msrd_pkg::CODE_NEWLINE);

	// colour 0 fill to the row end, nothing when already at or past it
	assign fill_len = (column < cfg.row_width) ? (cfg.row_width - column) : 16'd0;

	// requested run length
	always_comb begin
		priority if (is_newline) begin
			len_raw = {16'd0, fill_len};
		end else if (code_byte[7]) begin
			len_raw = {25'd0, code_byte[6:0] & msrd_pkg::RUN_MASK};
		end else begin
			len_raw = {24'd0, code_byte};
		end
	end

	// clip at what is left of the image
	assign clip = (len_raw > rest);
	assign len  = clip ? rest : len_raw;

	assign column_sum = is_newline ? 16'd0 : (column + len[15:0]);

	// result and state update
	always_comb begin
		if (is_end) begin
			run.pixel_color = 1'b0;
			run.run_length  = rest;
			run.overflow    = 1'b0;
			run.last_run    = 1'b1;
			column_nxt      = 16'd0;
			emitted_nxt     = 32'd0;
			rest_nxt        = cfg.total;
		end else begin
			run.pixel_color = !is_newline && !code_byte[7];
			run.run_length  = len;
			run.overflow    = clip;
			run.last_run    = 1'b0;
			column_nxt      = (column_sum == cfg.row_width) ? 16'd0 : column_sum;
			emitted_nxt     = emitted + len;
			rest_nxt        = rest - len;
		end
	end

endmodule
